[design/pfe_pkg.sv]
// Shared constants for the postfix expression evaluator.
// Holds stack and value sizes and the ASCII codes of digits and operators.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int VALUE_BITS  = 32;
	localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
	localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
	localparam int STEP_BITS   = $clog2(VALUE_BITS);
	localparam int SYM_BITS    = 8;
	localparam int OUT_BITS    = ((VALUE_BITS + 3 + 7) / 8) * 8;

	localparam logic [SYM_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_BITS-1:0] CH_NINE  = 8'h39;
	localparam logic [SYM_BITS-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_BITS-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_BITS-1:0] CH_MUL   = 8'h2A;
	localparam logic [SYM_BITS-1:0] CH_DIV   = 8'h2F;
	localparam logic [SYM_BITS-1:0] CH_MOD   = 8'h25;

	typedef logic [VALUE_BITS-1:0] value_t;

	// -1 in two's complement: the value of an empty stack
	localparam value_t EMPTY_VALUE = '1;

endpackage

`default_nettype wire

[design/postfix_expression_evaluator_top.sv]
// Postfix expression evaluator: operand stack in a synchronous RAM plus sequencer.
// Instantiates pfe_divider; depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  Input channel (s_*): one ASCII character per item in s_tdata, s_tlast marks
//  the final character of an expression. Digits push, + - * / % pop two and
//  push (second OP top); other characters are skipped.
//  Output channel (m_*): one item per expression, after the character marked
//  last: the stack top (-1 if empty) and the underflow, overflow and
//  divide-by-zero flags. Stack and flags then clear for the next expression.
//  Steps per input item, set by the sequencer and the single RAM read port:
//   digit or skipped character   taken directly in the idle state
//   + - *                        two reads, execute, write back
//   / %                          two reads, execute, the 32-step iterative divider,
//                                write back (no divider when the divisor is zero)
//   last marker                  then read the top and load output
//  The output register holds its item until m_tready; the block keeps taking
//  input items meanwhile and only waits if a second result is ready first.
//  Reset clears the count, flags, sequencer and output valid; the RAM content
//  is not cleared, entries above the count are never used.
module postfix_expression_evaluator_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [pfe_pkg::SYM_BITS-1:0]   s_tdata,  // [7:0] symbol
	input  wire                            s_tlast,  // last_symbol
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [pfe_pkg::OUT_BITS-1:0]   m_tdata   // value, underflow, overflow,
	                                                 // divide_by_zero, zero fill
);
	import pfe_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POP1 = 3'd1;
	localparam logic [2:0] S_POP2 = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_PUSH = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;
	localparam logic [2:0] S_LOAD = 3'd7;

	// operand stack
	value_t stack_mem [STACK_DEPTH];
	value_t rd_data_q;

	logic [2:0]          state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                und_q;
	logic                ovf_q;
	logic                dbz_q;
	logic [SYM_BITS-1:0] op_q;
	logic                last_q;
	value_t              opa_q;   // second from top
	value_t              opb_q;   // top
	value_t              res_q;

	logic                   m_tvalid_q;
	logic [OUT_BITS-1:0]    m_tdata_q;

	logic                   accept;
	logic                   is_digit;
	logic                   is_op;
	logic                   is_divop;
	logic                   cnt_empty;
	logic                   wr_en;
	logic [ADDR_BITS-1:0]   wr_addr;
	value_t                 wr_data;
	logic [ADDR_BITS-1:0]   rd_addr;
	value_t                 digit_value;
	value_t                 stack_top;
	value_t                 product;
	logic                   div_start;
	logic                   div_done;
	value_t                 div_quo;
	value_t                 div_rem;
	logic                   out_free;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
	assign is_op     = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS) || (s_tdata == CH_MUL)
	                || (s_tdata == CH_DIV) || (s_tdata == CH_MOD);
	assign is_divop  = (op_q == CH_DIV) || (op_q == CH_MOD);
	assign cnt_empty = (cnt_q == '0);
	assign digit_value = VALUE_BITS'(s_tdata[3:0] - CH_ZERO[3:0]);
	assign stack_top = cnt_empty ? EMPTY_VALUE : rd_data_q;
	assign product   = opa_q * opb_q;
	assign div_start = (state_q == S_EXEC) && is_divop && (opb_q != '0);
	assign out_free  = !m_tvalid_q || m_tready;

	// second read goes one below the top; every other read targets the top
	always_comb begin
		case (state_q)
			S_POP1:  rd_addr = ADDR_BITS'(cnt_q - CNT_BITS'(2));
			default: rd_addr = ADDR_BITS'(cnt_q - CNT_BITS'(1));
		endcase
	end

	// write a digit at accept, or the operator result in the push state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[ADDR_BITS-1:0];
		wr_data = res_q;
		if (state_q == S_PUSH) begin
			wr_en = 1'b1;
		end else if (accept && is_digit && (cnt_q != CNT_BITS'(STACK_DEPTH))) begin
			wr_en   = 1'b1;
			wr_data = digit_value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	pfe_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (opa_q),
		.divisor   (opb_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer, count and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			und_q      <= 1'b0;
			ovf_q      <= 1'b0;
			dbz_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load a new item, or drop valid once the current one is taken
			if ((state_q == S_LOAD) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_digit) begin
							if (cnt_q == CNT_BITS'(STACK_DEPTH)) begin
								ovf_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= s_tlast ? S_FIN : S_IDLE;
						end else if (is_op) begin
							state_q <= S_POP1;
						end else begin
							state_q <= s_tlast ? S_FIN : S_IDLE;
						end
					end
				end
				S_POP1, S_POP2: begin
					// pop: an empty stack reads -1 and leaves the count at zero
					if (cnt_empty) begin
						und_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= (state_q == S_POP1) ? S_POP2 : S_EXEC;
				end
				S_EXEC: begin
					if (is_divop && (opb_q == '0)) begin
						dbz_q   <= 1'b1;
						state_q <= S_PUSH;
					end else if (is_divop) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					// result always fits: it follows two pops
					cnt_q   <= cnt_q + 1'b1;
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// hold until the output register is free, then clear for the next run
					if (out_free) begin
						cnt_q      <= '0;
						und_q      <= 1'b0;
						ovf_q      <= 1'b0;
						dbz_q      <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tdata;
			last_q <= s_tlast;
		end
		if (state_q == S_POP1) begin
			opb_q <= stack_top;
		end
		if (state_q == S_POP2) begin
			opa_q <= stack_top;
		end
		if (state_q == S_EXEC) begin
			case (op_q)
				CH_PLUS:  res_q <= opa_q + opb_q;
				CH_MINUS: res_q <= opa_q - opb_q;
				CH_MUL:   res_q <= product;
				default:  res_q <= '0;
			endcase
		end
		if ((state_q == S_DIV) && div_done) begin
			res_q <= (op_q == CH_MOD) ? div_rem : div_quo;
		end
		if ((state_q == S_LOAD) && out_free) begin
			m_tdata_q <= OUT_BITS'({dbz_q, ovf_q, und_q | cnt_empty, stack_top});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_clear_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (cnt_q == '0) && !und_q && !ovf_q && !dbz_q)
		else $error("stack state not cleared after result");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (opb_q != '0) && is_divop)
		else $error("divider started with zero divisor or wrong operator");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the wait state");
`endif

endmodule

`default_nettype wire

[design/pfe_divider.sv]
// Iterative signed divider, one quotient bit per cycle.
// Truncating quotient, remainder with the sign of the dividend.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfe_divider (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  pfe_pkg::value_t  dividend,
	input  pfe_pkg::value_t  divisor,
	output logic             done,
	output pfe_pkg::value_t  quotient,
	output pfe_pkg::value_t  remainder
);
	import pfe_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	value_t               rem_q;
	value_t               quo_q;
	value_t               den_q;
	logic                 qneg_q;
	logic                 rneg_q;

	logic [VALUE_BITS:0]  shifted;
	logic                 fits;
	value_t               rem_next;
	value_t               dividend_mag;
	value_t               divisor_mag;

	assign dividend_mag = dividend[VALUE_BITS-1] ? (~dividend + 1'b1) : dividend;
	assign divisor_mag  = divisor[VALUE_BITS-1] ? (~divisor + 1'b1) : divisor;

	// shift in the next dividend bit, subtract when the divisor fits
	assign shifted  = {rem_q, quo_q[VALUE_BITS-1]};
	assign fits     = shifted >= {1'b0, den_q};
	assign rem_next = fits ? VALUE_BITS'(shifted - {1'b0, den_q}) : shifted[VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend_mag;
			den_q  <= divisor_mag;
			qneg_q <= dividend[VALUE_BITS-1] ^ divisor[VALUE_BITS-1];
			rneg_q <= dividend[VALUE_BITS-1];
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

`default_nettype wire
